// File: src/ntcavg_pkg.sv
// Shared constants for the NTC averaging temperature unit: field widths,
// clamp limit and the rising ADC threshold table. No dependencies.
package ntcavg_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int IDX_W       = 7;
	localparam int TBL_ENTRIES = 126;

	localparam logic [IDX_W-1:0] TEMP_MAX = IDX_W'(99);

	localparam logic [SAMPLE_W-1:0] NTC_TABLE [TBL_ENTRIES] = '{
		12'd1054, 12'd1091, 12'd1128, 12'd1165, 12'd1203, 12'd1242, 12'd1280, 12'd1320,
		12'd1359, 12'd1399, 12'd1439, 12'd1479, 12'd1520, 12'd1560, 12'd1601, 12'd1642,
		12'd1683, 12'd1724, 12'd1765, 12'd1805, 12'd1846, 12'd1887, 12'd1927, 12'd1968,
		12'd2008, 12'd2048, 12'd2087, 12'd2126, 12'd2165, 12'd2204, 12'd2242, 12'd2280,
		12'd2318, 12'd2355, 12'd2391, 12'd2427, 12'd2463, 12'd2498, 12'd2533, 12'd2567,
		12'd2601, 12'd2634, 12'd2667, 12'd2699, 12'd2730, 12'd2761, 12'd2791, 12'd2821,
		12'd2850, 12'd2879, 12'd2907, 12'd2935, 12'd2962, 12'd2988, 12'd3014, 12'd3040,
		12'd3064, 12'd3089, 12'd3113, 12'd3136, 12'd3158, 12'd3181, 12'd3202, 12'd3224,
		12'd3244, 12'd3264, 12'd3284, 12'd3303, 12'd3322, 12'd3341, 12'd3359, 12'd3376,
		12'd3393, 12'd3410, 12'd3426, 12'd3442, 12'd3457, 12'd3472, 12'd3487, 12'd3501,
		12'd3515, 12'd3529, 12'd3542, 12'd3555, 12'd3568, 12'd3580, 12'd3592, 12'd3603,
		12'd3615, 12'd3626, 12'd3637, 12'd3647, 12'd3657, 12'd3667, 12'd3677, 12'd3687,
		12'd3696, 12'd3705, 12'd3714, 12'd3722, 12'd3730, 12'd3739, 12'd3747, 12'd3754,
		12'd3762, 12'd3769, 12'd3776, 12'd3783, 12'd3790, 12'd3797, 12'd3803, 12'd3809,
		12'd3815, 12'd3821, 12'd3827, 12'd3833, 12'd3839, 12'd3844, 12'd3849, 12'd3854,
		12'd3859, 12'd3864, 12'd3869, 12'd3874, 12'd3878, 12'd3883
	};

endpackage

// File: src/ntcavg_lookup.sv
// Threshold table search: first entry at or above the value, and the clamped
// temperature. Depends on ntcavg_pkg for the table and widths.
module ntcavg_lookup
	import ntcavg_pkg::*;
(
	input  logic [SAMPLE_W-1:0] value,
	output logic [IDX_W-1:0]    table_index,
	output logic [IDX_W-1:0]    temperature
);

	always_comb begin
		table_index = '0;
		// scan from the top so the lowest matching position wins
		for (int i = TBL_ENTRIES - 1; i >= 0; i--) begin
			if (value <= NTC_TABLE[i]) begin
				table_index = IDX_W'(i);
			end
		end
		temperature = (table_index > TEMP_MAX) ? TEMP_MAX : table_index;
	end

endmodule

// File: src/ntc_average_table_temperature_unit.sv
// NTC temperature unit: moving average over a window memory with running sum,
// then table lookup. Depends on ntcavg_pkg and ntcavg_lookup.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  s_      | in  | [11:0] sample, [15:12] ignored              | -
//  m_      | out | [11:0] filtered_value, [18:12] table_index,  | [0] window_full
//          |     | [25:19] temperature, [31:26] zero           |
//
// One item per cycle sustained while m_tready stays high; an accepted item passes the
// stage 1 to 4 registers in order before m_tvalid rises. Stage 1 waits on the registered
// window memory read of the slot being replaced, stage 2 holds the running sum, stage 3
// the reciprocal-multiply mean (the raw sample until the window is full), stage 4 the
// table search. A same-slot write and read in the same cycle is forwarded. Reset clears the
// pipeline valids, fill count, pointer and sum; the memory needs no clearing. Each stage
// stalls only when the stage after it is full and stalled, stage 4 when m_tready is low.
module ntc_average_table_temperature_unit
	import ntcavg_pkg::*;
#(
	parameter int WINDOW = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [11:0] filtered_value, [18:12] table_index, [25:19] temperature
	output logic        m_tuser    // [0] window_full
);

	localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int L      = $clog2(WINDOW);
	localparam int SUM_W  = SAMPLE_W + L;
	localparam int SH     = SUM_W + L;
	localparam int MW     = SUM_W + 1;
	localparam int PROD_W = SUM_W + MW;
	localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW - 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);

	logic [SAMPLE_W-1:0] win_mem_q [WINDOW];
	logic [SAMPLE_W-1:0] rd_q;

	logic [PTR_W-1:0]  wp_q;
	logic [FILL_W-1:0] fill_q;
	logic [SUM_W-1:0]  sum_q;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic                adv1, adv2, adv3, adv4;
	logic                accept;

	logic [SAMPLE_W-1:0] sample_s1;
	logic [PTR_W-1:0]    wp_s1;
	logic                full_s1;
	logic                fwd_s1;
	logic [SAMPLE_W-1:0] fwd_data_s1;

	logic [SUM_W-1:0]    sum_s2;
	logic [SAMPLE_W-1:0] sample_s2;
	logic                full_s2;

	logic [SAMPLE_W-1:0] filt_s3;
	logic                full_s3;

	logic [SAMPLE_W-1:0] filt_s4;
	logic                full_s4;
	logic [IDX_W-1:0]    idx_s4;
	logic [IDX_W-1:0]    temp_s4;

	logic [SAMPLE_W-1:0] old_sample;
	logic [SUM_W-1:0]    sum_next;
	logic [PROD_W-1:0]   prod;
	logic [SAMPLE_W-1:0] mean;
	logic [IDX_W-1:0]    idx_c;
	logic [IDX_W-1:0]    temp_c;

	assign adv4   = !v_s4 || m_tready;
	assign adv3   = !v_s3 || adv4;
	assign adv2   = !v_s2 || adv3;
	assign adv1   = !v_s1 || adv2;
	assign accept = s_tvalid && adv1;
	assign s_tready = adv1;

	assign old_sample = fwd_s1 ? fwd_data_s1 : rd_q;
	assign sum_next   = full_s1
		? (sum_q - SUM_W'(old_sample) + SUM_W'(sample_s1))
		: (sum_q + SUM_W'(sample_s1));

	assign prod = PROD_W'(sum_s2) * PROD_W'(RECIP);
	assign mean = prod[SH +: SAMPLE_W];

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			wp_q   <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (accept) begin
				wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + PTR_W'(1);
				if (fill_q != FILL_MAX) fill_q <= fill_q + FILL_W'(1);
			end
			if (v_s1 && adv2) sum_q <= sum_next;
		end
	end

	// window memory: read the slot being replaced on accept, write as stage 1 leaves
	always_ff @(posedge clk) begin
		if (accept) rd_q <= win_mem_q[wp_q];
		if (v_s1 && adv2) win_mem_q[wp_s1] <= sample_s1;
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1   <= s_tdata[SAMPLE_W-1:0];
			wp_s1       <= wp_q;
			full_s1     <= (fill_q == FILL_MAX);
			fwd_s1      <= v_s1 && adv2 && (wp_s1 == wp_q);
			fwd_data_s1 <= sample_s1;
		end
		if (v_s1 && adv2) begin
			sum_s2    <= sum_next;
			sample_s2 <= sample_s1;
			full_s2   <= full_s1;
		end
		if (v_s2 && adv3) begin
			filt_s3 <= full_s2 ? mean : sample_s2;
			full_s3 <= full_s2;
		end
		if (v_s3 && adv4) begin
			filt_s4 <= filt_s3;
			full_s4 <= full_s3;
			idx_s4  <= idx_c;
			temp_s4 <= temp_c;
		end
	end

	ntcavg_lookup u_lookup (
		.value       (filt_s3),
		.table_index (idx_c),
		.temperature (temp_c)
	);

	assign m_tvalid = v_s4;
	assign m_tuser  = full_s4;
	assign m_tdata  = {6'd0, temp_s4, idx_s4, filt_s4};

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for ntc_average_table_temperature_unit: drives ADC samples and checks each result
// against a predictor of the moving-average window and the NTC table lookup.
// Depends on ntcavg_pkg and the unit itself.
module tb_top
	import ntcavg_pkg::*;
();

	localparam int AVG_LEN     = 8;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [SAMPLE_W-1:0] filtered;
		logic                full;
		logic [IDX_W-1:0]    position;
		logic [IDX_W-1:0]    degrees;
	} reading_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;    // [11:0] sample, [15:12] ignored by the unit
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;    // [11:0] filtered_value, [18:12] table_index, [25:19] temperature
	logic        m_tuser;    // [0] window_full

	// predictor state
	logic [SAMPLE_W-1:0] avg_slots [AVG_LEN];
	logic [14:0]         avg_total;
	int unsigned         avg_filled;
	logic [2:0]          avg_oldest;

	reading_t pending_readings [$];
	int       err_count;
	int       send_idle_pct;
	int       sink_stall_pct;
	bit       hold_pending;

	ntc_average_table_temperature_unit #(.WINDOW(AVG_LEN)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [IDX_W-1:0] table_position(input logic [SAMPLE_W-1:0] level);
		for (int i = 0; i < TBL_ENTRIES; i++) begin
			if (level <= NTC_TABLE[i])
				return IDX_W'(i);
		end
		return '0;
	endfunction

	// Advance the window by one sample and queue the reading it should give.
	task automatic predict_reading(input logic [SAMPLE_W-1:0] sample);
		reading_t r;
		if (avg_filled < AVG_LEN) begin
			avg_slots[avg_filled] = sample;
			avg_total             = avg_total + sample;
			avg_filled++;
			r.filtered = sample;
			r.full     = 1'b0;
		end else begin
			avg_total              = avg_total - avg_slots[avg_oldest] + sample;
			avg_slots[avg_oldest]  = sample;
			avg_oldest             = avg_oldest + 3'd1;
			r.filtered = SAMPLE_W'(avg_total / AVG_LEN);
			r.full     = 1'b1;
		end
		r.position = table_position(r.filtered);
		r.degrees  = (r.position > TEMP_MAX) ? TEMP_MAX : r.position;
		pending_readings.push_back(r);
	endtask

	// Offer one sample with random stray upper bits; keep valid high once accepted.
	task automatic send_sample(input int value);
		logic [SAMPLE_W-1:0] sample;
		sample = SAMPLE_W'(value);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'($urandom_range(0, 15)), sample};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_reading(sample);
	endtask

	// Mostly steady levels with noise so that full-window means land across the table,
	// mixed with single uniform samples and rail values.
	task automatic send_noisy_levels(input int count);
		int sent;
		int level;
		int amp;
		int run_len;
		int value;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					send_sample($urandom_range(0, 4095));
					sent++;
				end
				2: begin
					send_sample($urandom_range(0, 1) ? 4095 : 0);
					sent++;
				end
				default: begin
					case ($urandom_range(0, 3))
						0: level = $urandom_range(0, 4095);
						1: level = NTC_TABLE[$urandom_range(0, TBL_ENTRIES - 1)] + $urandom_range(0, 1);
						2: level = $urandom_range(3700, 4095);
						default: level = $urandom_range(0, 1100);
					endcase
					amp     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
					run_len = $urandom_range(8, 24);
					for (int k = 0; k < run_len && sent < count; k++) begin
						value = level + int'($urandom_range(0, 2 * amp)) - amp;
						if (value < 0)
							value = 0;
						if (value > 4095)
							value = 4095;
						send_sample(value);
						sent++;
					end
				end
			endcase
		end
	endtask

	// Fill with rail and threshold-edge samples, then settle the full window at the top
	// rail (above the table) and just past the clamp point.
	task automatic test_fill_and_edges();
		int fill_values [8] = '{0, 4095, 1054, 1055, 3883, 3884, 3722, 3723};
		foreach (fill_values[i])
			send_sample(fill_values[i]);
		repeat (8)
			send_sample(4095);
		repeat (8)
			send_sample(3723);
	endtask

	task automatic test_slow_sink();
		send_idle_pct  = 27;
		sink_stall_pct = 76;
		send_noisy_levels(300);
	endtask

	task automatic test_slow_source();
		send_idle_pct  = 76;
		sink_stall_pct = 27;
		send_noisy_levels(300);
	endtask

	task automatic test_streaming();
		send_idle_pct  = 0;
		sink_stall_pct = 0;
		send_noisy_levels(300);
	endtask

	// Hold the sink off for a long stretch while samples keep coming, so the unit backs up.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		sink_stall_pct = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		hold_pending = 1'b1;
		send_noisy_levels(60);
	endtask

	task automatic check_field(input string name, input int expv, input int actv);
		if (expv != actv) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, actv);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h/%b", $time, m_tdata,
					m_tuser);
				err_count++;
			end else begin
				want = pending_readings.pop_front();
				check_field("filtered_value", want.filtered, m_tdata[11:0]);
				check_field("window_full", want.full, m_tuser);
				check_field("table_index", want.position, m_tdata[18:12]);
				check_field("temperature", want.degrees, m_tdata[25:19]);
			end
		end
	end

	// Sink side: random stalls, or one long hold when asked.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1)
					@(posedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	initial begin
		#400000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		err_count      = 0;
		hold_pending   = 1'b0;
		send_idle_pct  = 27;
		sink_stall_pct = 76;
		avg_total      = '0;
		avg_filled     = 0;
		avg_oldest     = '0;
		foreach (avg_slots[i])
			avg_slots[i] = '0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_and_edges();
		test_slow_sink();
		test_slow_source();
		test_streaming();
		test_backpressure();
		s_tvalid <= 1'b0;

		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
src/ntcavg_pkg.sv
src/ntcavg_lookup.sv
src/ntc_average_table_temperature_unit.sv
test/tb_top.sv
